// ===== rtl/msgd_pkg.sv =====
// ----------------------------------------------------------------------------
// msgd_pkg
// shared widths, opcodes, register indexes and the saturation helper for the
// momentum sgd parameter update core
// ----------------------------------------------------------------------------
`default_nettype none

package msgd_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int COEF_W      = 16;

    // products of an unsigned coefficient (zero-extended) and a signed value
    localparam int PROD_W      = COEF_W + 1 + VALUE_WIDTH;
    localparam int DECAY_W     = COEF_W + 2 + VALUE_WIDTH;
    // wide enough for any pre-saturation sum
    localparam int SUM_W       = VALUE_WIDTH + 4;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_LOAD   = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [1:0] REG_MOMENTUM = 2'd0;
    localparam logic [1:0] REG_STEP     = 2'd1;
    localparam logic [1:0] REG_L1       = 2'd2;
    localparam logic [1:0] REG_L2       = 2'd3;

    localparam logic [COEF_W-1:0] MOMENTUM_RESET = 16'd58982;
    localparam logic [COEF_W-1:0] STEP_RESET     = 16'd66;
    localparam logic [COEF_W-1:0] L1_RESET       = 16'd0;
    localparam logic [COEF_W-1:0] L2_RESET       = 16'd0;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   hit;
    } sat_t;

    // clamp a two's complement sum to VALUE_WIDTH signed bits
    function automatic sat_t saturate(input logic [SUM_W-1:0] x);
        sat_t r;
        logic top_ones;
        logic top_zeros;
        top_ones  = &x[SUM_W-1:VALUE_WIDTH-1];
        top_zeros = ~|x[SUM_W-1:VALUE_WIDTH-1];
        if (top_ones || top_zeros)
        begin
            r.value = x[VALUE_WIDTH-1:0];
            r.hit   = 1'b0;
        end
        else if (x[SUM_W-1])
        begin
            r.value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            r.hit   = 1'b1;
        end
        else
        begin
            r.value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            r.hit   = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/msgd_ram.sv =====
// ----------------------------------------------------------------------------
// msgd_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module msgd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/momentum_sgd_param_update_core.sv =====
// ----------------------------------------------------------------------------
// momentum_sgd_param_update_core
// parameter and momentum store with momentum sgd and l1/l2 weight decay
// ----------------------------------------------------------------------------
//
//   channel   signals                                      handshake
//   -------   -------------------------------------------  -------------------
//   item in   opcode, entry_index, operand                 start && !busy
//   result    param_value, momentum_value, saturated       done, one cycle
//   config    psel penable pwrite paddr pwdata prdata      apb, pready tied 1
//
// an item passes through ram read, multiply stage, add/saturate and write back.
// busy is high in ST_MUL and ST_FIN after acceptance; the result strobe comes
// in the cycle after ST_FIN, when the next item may already be accepted.
// the stores have no reset and are not cleared: an entry must be loaded first.
// the receiver cannot stall, so nothing waits on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module momentum_sgd_param_update_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [1:0]                           opcode,
    input  wire logic [msgd_pkg::ADDR_W-1:0]          entry_index,
    input  wire logic signed [msgd_pkg::VALUE_WIDTH-1:0] operand,
    output logic                                      done,
    output logic signed [msgd_pkg::VALUE_WIDTH-1:0]   param_value,
    output logic signed [msgd_pkg::VALUE_WIDTH-1:0]   momentum_value,
    output logic                                      saturated,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [msgd_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [msgd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic      [msgd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                      pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam int VW = msgd_pkg::VALUE_WIDTH;
    localparam int CW = msgd_pkg::COEF_W;
    localparam int FB = msgd_pkg::FRAC_BITS;
    localparam int SW = msgd_pkg::SUM_W;
    localparam int PW = msgd_pkg::PROD_W;
    localparam int DW = msgd_pkg::DECAY_W;

    // ---------------- configuration ----------------
    logic [CW-1:0] momentum_coef_reg;
    logic [CW-1:0] step_size_reg;
    logic [CW-1:0] l1_coef_reg;
    logic [CW-1:0] l2_coef_reg;
    logic [CW-1:0] sl1_reg;
    logic [CW-1:0] sl2_reg;
    logic [2*CW-1:0] sl1_prod;
    logic [2*CW-1:0] sl2_prod;
    logic          cfg_write;
    logic [1:0]    cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            momentum_coef_reg <= msgd_pkg::MOMENTUM_RESET;
            step_size_reg     <= msgd_pkg::STEP_RESET;
            l1_coef_reg       <= msgd_pkg::L1_RESET;
            l2_coef_reg       <= msgd_pkg::L2_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                msgd_pkg::REG_MOMENTUM: momentum_coef_reg <= pwdata[CW-1:0];
                msgd_pkg::REG_STEP:     step_size_reg     <= pwdata[CW-1:0];
                msgd_pkg::REG_L1:       l1_coef_reg       <= pwdata[CW-1:0];
                msgd_pkg::REG_L2:       l2_coef_reg       <= pwdata[CW-1:0];
                default:                momentum_coef_reg <= momentum_coef_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            msgd_pkg::REG_MOMENTUM: prdata = {{(msgd_pkg::APB_DATA_W-CW){1'b0}}, momentum_coef_reg};
            msgd_pkg::REG_STEP:     prdata = {{(msgd_pkg::APB_DATA_W-CW){1'b0}}, step_size_reg};
            msgd_pkg::REG_L1:       prdata = {{(msgd_pkg::APB_DATA_W-CW){1'b0}}, l1_coef_reg};
            msgd_pkg::REG_L2:       prdata = {{(msgd_pkg::APB_DATA_W-CW){1'b0}}, l2_coef_reg};
            default:                prdata = '0;
        endcase
    end

    // step*l1 and step*l2 only follow the registers, so they are kept ready
    assign sl1_prod = step_size_reg * l1_coef_reg;
    assign sl2_prod = step_size_reg * l2_coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sl1_reg <= '0;
            sl2_reg <= '0;
        end
        else
        begin
            sl1_reg <= sl1_prod[2*CW-1:FB];
            sl2_reg <= sl2_prod[2*CW-1:FB];
        end
    end

    // ---------------- stores ----------------
    logic          accept;
    logic          store_we;
    logic [VW-1:0] param_rd;
    logic [VW-1:0] mom_rd;
    logic [VW-1:0] param_wr;
    logic [VW-1:0] mom_wr;
    logic [msgd_pkg::ADDR_W-1:0] idx_reg;

    assign accept = start && !busy;

    msgd_ram #(
        .WIDTH (VW),
        .DEPTH (msgd_pkg::STORE_DEPTH)
    ) u_param_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (idx_reg),
        .wdata (param_wr),
        .raddr (entry_index),
        .rdata (param_rd)
    );

    msgd_ram #(
        .WIDTH (VW),
        .DEPTH (msgd_pkg::STORE_DEPTH)
    ) u_momentum_ram (
        .clk   (clk),
        .we    (store_we),
        .waddr (idx_reg),
        .wdata (mom_wr),
        .raddr (entry_index),
        .rdata (mom_rd)
    );

    // ---------------- sequencer ----------------
    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = accept ? ST_MUL : ST_IDLE;
            ST_MUL:  state_next = ST_FIN;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    // ---------------- item capture ----------------
    logic [1:0]    op_reg;
    logic [VW-1:0] operand_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= opcode;
            idx_reg     <= entry_index;
            operand_reg <= operand;
        end
    end

    // ---------------- multiply stage ----------------
    logic signed [PW-1:0] keep_p_reg;
    logic signed [PW-1:0] push_p_reg;
    logic signed [DW-1:0] decay_p_reg;
    logic [VW-1:0]        w_reg;
    logic [VW-1:0]        m_reg;
    logic [CW:0]          decay_f;

    // 1 - step*l2 in q1.16, at most 1.0
    assign decay_f = {1'b1, {CW{1'b0}}} - {1'b0, sl2_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            keep_p_reg  <= $signed({1'b0, momentum_coef_reg}) * $signed(mom_rd);
            push_p_reg  <= $signed({1'b0, step_size_reg}) * $signed(operand_reg);
            decay_p_reg <= $signed({1'b0, decay_f}) * $signed(param_rd);
            w_reg       <= param_rd;
            m_reg       <= mom_rd;
        end
    end

    // ---------------- add, saturate, write back ----------------
    logic [PW-FB-1:0] keep_s;
    logic [PW-FB-1:0] push_s;
    logic [DW-FB-1:0] decay_s;
    logic [SW-1:0]    mom_sum;
    logic [SW-1:0]    val_sum;
    logic [SW-1:0]    l1_term;
    msgd_pkg::sat_t   mom_sat;
    msgd_pkg::sat_t   val_sat;
    logic             sat_out;

    always_comb
    begin
        keep_s  = keep_p_reg[PW-1:FB];
        push_s  = push_p_reg[PW-1:FB];
        decay_s = decay_p_reg[DW-1:FB];
        mom_sum = {{(SW-(PW-FB)){keep_s[PW-FB-1]}}, keep_s}
                - {{(SW-(PW-FB)){push_s[PW-FB-1]}}, push_s};
        mom_sat = msgd_pkg::saturate(mom_sum);

        // sign(w) * step*l1, subtracted below
        if (w_reg[VW-1])
            l1_term = {{(SW-CW){1'b1}}, ~sl1_reg} + {{(SW-1){1'b0}}, 1'b1};
        else if (|w_reg)
            l1_term = {{(SW-CW){1'b0}}, sl1_reg};
        else
            l1_term = '0;

        val_sum  = '0;
        param_wr = w_reg;
        mom_wr   = m_reg;
        sat_out  = 1'b0;
        case (op_reg)
            msgd_pkg::OP_WEIGHT:
            begin
                val_sum  = {{(SW-(DW-FB)){decay_s[DW-FB-1]}}, decay_s} - l1_term
                         + {{(SW-VW){mom_sat.value[VW-1]}}, mom_sat.value};
                val_sat  = msgd_pkg::saturate(val_sum);
                param_wr = val_sat.value;
                mom_wr   = mom_sat.value;
                sat_out  = mom_sat.hit || val_sat.hit;
            end
            msgd_pkg::OP_BIAS:
            begin
                val_sum  = {{(SW-VW){w_reg[VW-1]}}, w_reg}
                         + {{(SW-VW){mom_sat.value[VW-1]}}, mom_sat.value};
                val_sat  = msgd_pkg::saturate(val_sum);
                param_wr = val_sat.value;
                mom_wr   = mom_sat.value;
                sat_out  = mom_sat.hit || val_sat.hit;
            end
            msgd_pkg::OP_LOAD:
            begin
                val_sat  = msgd_pkg::saturate({{(SW-VW){operand_reg[VW-1]}}, operand_reg});
                param_wr = val_sat.value;
                mom_wr   = '0;
                sat_out  = val_sat.hit;
            end
            default:
            begin
                val_sat  = msgd_pkg::saturate(val_sum);
            end
        endcase
    end

    assign store_we = (state_reg == ST_FIN) && (op_reg != msgd_pkg::OP_READ);

    // ---------------- result ----------------
    logic          done_reg;
    logic [VW-1:0] param_out_reg;
    logic [VW-1:0] mom_out_reg;
    logic          sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN)
        begin
            param_out_reg <= param_wr;
            mom_out_reg   <= mom_wr;
            sat_reg       <= sat_out;
        end
    end

    assign done           = done_reg;
    assign param_value    = param_out_reg;
    assign momentum_value = mom_out_reg;
    assign saturated      = sat_reg;

endmodule

`default_nettype wire
